FILE: hdl/ycfb_pkg.sv
// Shared types, constants and helpers of the YUV 4:2:2 colour filter with column bins.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ycfb_pkg;

   // Frame geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int X_W        = $clog2(MAX_WIDTH);       // even pixel column
   localparam int ROW_W      = $clog2(MAX_HEIGHT);      // row index
   localparam int DIM_W      = 11;                      // configured width and height
   localparam int DBL_W      = DIM_W + 1;               // twice the width

   // Division by three as a multiply by 2731 / 2^13; exact for operands up to 2 * MAX_WIDTH
   localparam int RECIP3       = 2731;
   localparam int RECIP3_SHIFT = 13;
   localparam int PROD3_W      = 2 * DBL_W;

   // Counters
   localparam int                 COUNT_W   = 21;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam int                 MATCH_W   = 2;        // matches in one macropixel, 0..2

   localparam logic [7:0] REJECT_CHROMA = 8'd127;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      REG_LUMA_MIN      = 3'd0,
      REG_LUMA_MAX      = 3'd1,
      REG_BLUE_DIFF_MIN = 3'd2,
      REG_BLUE_DIFF_MAX = 3'd3,
      REG_RED_DIFF_MIN  = 3'd4,
      REG_RED_DIFF_MAX  = 3'd5,
      REG_FRAME_WIDTH   = 3'd6,
      REG_FRAME_HEIGHT  = 3'd7
   } ycfb_reg_type;

   typedef enum logic [1:0] {
      BIN_LEFT   = 2'd0,
      BIN_MIDDLE = 2'd1,
      BIN_RIGHT  = 2'd2
   } ycfb_bin_type;

   typedef struct packed {
      logic [7:0]       luma_min;
      logic [7:0]       luma_max;
      logic [7:0]       blue_diff_min;
      logic [7:0]       blue_diff_max;
      logic [7:0]       red_diff_min;
      logic [7:0]       red_diff_max;
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
   } ycfb_cfg_type;

   typedef struct packed {
      logic [7:0] u_in;
      logic [7:0] y1_in;
      logic [7:0] v_in;
      logic [7:0] y2_in;
   } ycfb_req_type;

   typedef struct packed {
      logic [7:0]         u_out;
      logic [7:0]         y1_out;
      logic [7:0]         v_out;
      logic [7:0]         y2_out;
      logic               frame_done;
      logic [COUNT_W-1:0] match_count;
      logic [COUNT_W-1:0] left_bin_count;
      logic [COUNT_W-1:0] middle_bin_count;
      logic [COUNT_W-1:0] right_bin_count;
   } ycfb_rsp_type;

   // One classified macropixel on its way from front to back
   typedef struct packed {
      logic [7:0]         u_res;
      logic [7:0]         y1;
      logic [7:0]         v_res;
      logic [7:0]         y2;
      logic               frame_end;
      logic [MATCH_W-1:0] match_n;
      ycfb_bin_type       bin;
   } ycfb_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ycfb_qstat_type;

   function automatic logic [DIM_W-1:0] div3(input logic [DBL_W-1:0] v);
      logic [PROD3_W-1:0] prod;
      prod = PROD3_W'(v) * PROD3_W'(RECIP3);
      return prod[RECIP3_SHIFT +: DIM_W];
   endfunction

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] c,
                                                  input logic [MATCH_W-1:0] n);
      logic [COUNT_W:0] s;
      s = {1'b0, c} + (COUNT_W+1)'(n);
      return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hdl/ycfb_front.sv
// Front end: accepts macropixels, applies the colour thresholds, tracks the raster position.
// Depends on ycfb_pkg; feeds ycfb_queue.
`default_nettype none

module ycfb_front (
   input  wire                        clock,
   input  wire                        reset,
   input  ycfb_pkg::ycfb_cfg_type     cfg,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  ycfb_pkg::ycfb_req_type     req_data,
   input  ycfb_pkg::ycfb_qstat_type   q_stat,
   output logic                       push,
   output ycfb_pkg::ycfb_entry_type   entry
);
   import ycfb_pkg::*;

   logic [X_W-1:0]   x_ff, x_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [DIM_W-1:0] w_even, w_used, h_used;
   logic [DIM_W-1:0] thr_left, thr_mid;
   logic             chroma_ok, y1_ok, y2_ok;
   logic             row_end, frame_end;

   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   // Limit the geometry to what the counters can walk
   always_comb begin
      w_even = {cfg.frame_width[DIM_W-1:1], 1'b0};
      if (w_even > DIM_W'(MAX_WIDTH))
         w_used = DIM_W'(MAX_WIDTH);
      else if (w_even < DIM_W'(2))
         w_used = DIM_W'(2);
      else
         w_used = w_even;

      if (cfg.frame_height > DIM_W'(MAX_HEIGHT))
         h_used = DIM_W'(MAX_HEIGHT);
      else if (cfg.frame_height == '0)
         h_used = DIM_W'(1);
      else
         h_used = cfg.frame_height;
   end

   assign thr_left = div3({1'b0, w_used});
   assign thr_mid  = div3({w_used, 1'b0});

   assign chroma_ok = (req_data.u_in >= cfg.blue_diff_min) && (req_data.u_in <= cfg.blue_diff_max)
                   && (req_data.v_in >= cfg.red_diff_min) && (req_data.v_in <= cfg.red_diff_max);
   assign y1_ok = chroma_ok && (req_data.y1_in >= cfg.luma_min) && (req_data.y1_in <= cfg.luma_max);
   assign y2_ok = chroma_ok && (req_data.y2_in >= cfg.luma_min) && (req_data.y2_in <= cfg.luma_max);

   assign row_end   = ((DIM_W'(x_ff) + DIM_W'(2)) >= w_used);
   assign frame_end = row_end && ((DIM_W'(row_ff) + DIM_W'(1)) >= h_used);

   always_comb begin
      entry.u_res     = y1_ok ? req_data.u_in : REJECT_CHROMA;
      entry.y1        = req_data.y1_in;
      entry.v_res     = y2_ok ? req_data.v_in : REJECT_CHROMA;
      entry.y2        = req_data.y2_in;
      entry.frame_end = frame_end;
      entry.match_n   = MATCH_W'(y1_ok) + MATCH_W'(y2_ok);
      if (DIM_W'(x_ff) < thr_left)
         entry.bin = BIN_LEFT;
      else if (DIM_W'(x_ff) < thr_mid)
         entry.bin = BIN_MIDDLE;
      else
         entry.bin = BIN_RIGHT;
   end

   // Advance the raster position on every accepted macropixel
   always_comb begin
      x_in   = x_ff;
      row_in = row_ff;
      if (push) begin
         if (frame_end) begin
            x_in   = '0;
            row_in = '0;
         end else if (row_end) begin
            x_in   = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            x_in   = x_ff + X_W'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= '0;
         row_ff <= '0;
      end else begin
         x_ff   <= x_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/ycfb_queue.sv
// Short register queue between front and back of the colour filter.
// Depends on ycfb_pkg.
`default_nettype none

module ycfb_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  ycfb_pkg::ycfb_entry_type   push_entry,
   input  wire                        pop,
   output ycfb_pkg::ycfb_entry_type   pop_entry,
   output ycfb_pkg::ycfb_qstat_type   q_stat
);
   import ycfb_pkg::*;

   ycfb_entry_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign q_stat.full  = (level_ff == QLVL_W'(QUEUE_DEPTH));
   assign q_stat.empty = (level_ff == '0);
   assign pop_entry    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop)
         level_in = level_ff + QLVL_W'(1);
      else if (pop && !push)
         level_in = level_ff - QLVL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

FILE: hdl/ycfb_back.sv
// Back end: updates the frame and column bin counters and holds the result register.
// Depends on ycfb_pkg; drains ycfb_queue.
`default_nettype none

module ycfb_back (
   input  wire                        clock,
   input  wire                        reset,
   input  ycfb_pkg::ycfb_qstat_type   q_stat,
   input  ycfb_pkg::ycfb_entry_type   entry,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output ycfb_pkg::ycfb_rsp_type     rsp_data
);
   import ycfb_pkg::*;

   logic [COUNT_W-1:0] total_ff, total_in, total_nx;
   logic [COUNT_W-1:0] left_ff, left_in, left_nx;
   logic [COUNT_W-1:0] middle_ff, middle_in, middle_nx;
   logic [COUNT_W-1:0] right_ff, right_in, right_nx;
   logic               rsp_valid_ff, rsp_valid_in;
   ycfb_rsp_type       rsp_ff, rsp_in;

   // Take an entry whenever the result register is free or being emptied
   assign pop       = !q_stat.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      total_nx  = sat_add(total_ff, entry.match_n);
      left_nx   = left_ff;
      middle_nx = middle_ff;
      right_nx  = right_ff;
      case (entry.bin)
         BIN_LEFT:   left_nx   = sat_add(left_ff, entry.match_n);
         BIN_MIDDLE: middle_nx = sat_add(middle_ff, entry.match_n);
         BIN_RIGHT:  right_nx  = sat_add(right_ff, entry.match_n);
         default:    right_nx  = right_ff;
      endcase
   end

   always_comb begin
      total_in     = total_ff;
      left_in      = left_ff;
      middle_in    = middle_ff;
      right_in     = right_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         rsp_valid_in            = 1'b1;
         rsp_in.u_out            = entry.u_res;
         rsp_in.y1_out           = entry.y1;
         rsp_in.v_out            = entry.v_res;
         rsp_in.y2_out           = entry.y2;
         rsp_in.frame_done       = entry.frame_end;
         if (entry.frame_end) begin
            // Report the frame totals and start the next frame from zero
            rsp_in.match_count      = total_nx;
            rsp_in.left_bin_count   = left_nx;
            rsp_in.middle_bin_count = middle_nx;
            rsp_in.right_bin_count  = right_nx;
            total_in  = '0;
            left_in   = '0;
            middle_in = '0;
            right_in  = '0;
         end else begin
            rsp_in.match_count      = '0;
            rsp_in.left_bin_count   = '0;
            rsp_in.middle_bin_count = '0;
            rsp_in.right_bin_count  = '0;
            total_in  = total_nx;
            left_in   = left_nx;
            middle_in = middle_nx;
            right_in  = right_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         left_ff      <= '0;
         middle_ff    <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         left_ff      <= left_in;
         middle_ff    <= middle_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

FILE: hdl/yuv422_color_filter_bins_core.sv
// Top level of the YUV 4:2:2 colour threshold filter with three column bins.
// Depends on ycfb_pkg, ycfb_front, ycfb_queue and ycfb_back.
//
//   port group  direction  payload          transfer
//   req_*       in         ycfb_req_type    req_valid && !req_stall
//   rsp_*       out        ycfb_rsp_type    rsp_valid && !rsp_stall
//   csr_*       in         11-bit data      csr_write, index 0..7
//
// One macropixel per clock sustained while rsp_stall stays low; an accepted transaction is
// first written into the two-entry queue and then loaded into the result register, which
// presents it; rsp_stall can hold it in the queue between the two.
// req_stall rises only when the queue is full, which happens after rsp_stall holds the result.
// Reset is synchronous and active high; it clears position, counters, queue and valid flags
// and restores the default thresholds and a 128 x 96 frame.
// Write configuration only while no transaction is in flight.
`default_nettype none

module yuv422_color_filter_bins_core (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  ycfb_pkg::ycfb_req_type   req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output ycfb_pkg::ycfb_rsp_type   rsp_data,
   input  wire                      csr_write,
   input  wire [2:0]                csr_index,
   input  wire [ycfb_pkg::DIM_W-1:0] csr_wdata
);
   import ycfb_pkg::*;

   ycfb_cfg_type   cfg_ff, cfg_in;
   ycfb_qstat_type q_stat;
   ycfb_entry_type front_entry, back_entry;
   logic           front_push, back_pop;

   // Configuration registers: hold, take a write when enabled
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_LUMA_MIN:      cfg_in.luma_min      = csr_wdata[7:0];
            REG_LUMA_MAX:      cfg_in.luma_max      = csr_wdata[7:0];
            REG_BLUE_DIFF_MIN: cfg_in.blue_diff_min = csr_wdata[7:0];
            REG_BLUE_DIFF_MAX: cfg_in.blue_diff_max = csr_wdata[7:0];
            REG_RED_DIFF_MIN:  cfg_in.red_diff_min  = csr_wdata[7:0];
            REG_RED_DIFF_MAX:  cfg_in.red_diff_max  = csr_wdata[7:0];
            REG_FRAME_WIDTH:   cfg_in.frame_width   = csr_wdata;
            REG_FRAME_HEIGHT:  cfg_in.frame_height  = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.luma_min      <= 8'd0;
         cfg_ff.luma_max      <= 8'd255;
         cfg_ff.blue_diff_min <= 8'd0;
         cfg_ff.blue_diff_max <= 8'd255;
         cfg_ff.red_diff_min  <= 8'd0;
         cfg_ff.red_diff_max  <= 8'd255;
         cfg_ff.frame_width   <= DIM_W'(128);
         cfg_ff.frame_height  <= DIM_W'(96);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify and position each macropixel
   ycfb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (front_push),
      .entry     (front_entry)
   );

   // Decouple the input side from result back-pressure
   ycfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_entry (front_entry),
      .pop        (back_pop),
      .pop_entry  (back_entry),
      .q_stat     (q_stat)
   );

   // Count matches and deliver results
   ycfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .entry     (back_entry),
      .pop       (back_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // An accepted transaction is in the queue at the next edge
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !q_stat.empty)
      else $error("accepted transaction missing from queue");

   // A drained entry always shows up as a result
   a_pop_delivers: assert property (@(posedge clock) disable iff (reset)
      back_pop |=> rsp_valid)
      else $error("queue entry drained without a result");

   // No column bin can exceed the frame total
   a_bins_bounded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_done) |->
         (rsp_data.left_bin_count <= rsp_data.match_count) &&
         (rsp_data.middle_bin_count <= rsp_data.match_count) &&
         (rsp_data.right_bin_count <= rsp_data.match_count))
      else $error("column bin exceeds frame total");

endmodule

`default_nettype wire
